// File: sv/salc_pkg.sv
package salc_pkg;

  localparam int MAX_INDEX_BITS = 8;
  localparam int MAX_WAYS       = 8;
  localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
  localparam int SET_W          = MAX_INDEX_BITS;
  localparam int WAY_W          = $clog2(MAX_WAYS);
  localparam int RANK_W         = WAY_W;
  localparam int RANK_MAX       = MAX_WAYS - 1;
  localparam int ADDR_W         = 64;
  localparam int TAG_W          = 64;
  localparam int CNT_W          = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_IDX_WIDTH = 2'd0,
    CFG_BLK_WIDTH = 2'd1,
    CFG_WAYS      = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic hit;
    logic evict;
  } upd_res_t;

endpackage

// File: sv/salc_update.sv
module salc_update import salc_pkg::*; (
  input  row_t             row_in,
  input  logic [TAG_W-1:0] tag,
  input  logic [WAY_W:0]   nw,
  output row_t             row_out,
  output upd_res_t         res
);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    free_idx;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    target;
  logic                hit;
  logic                have_free;
  logic                evict;
  logic [RANK_W-1:0]   limit;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAY_W+1)'(w) < nw;
      match[w]  = in_use[w] && row_in[w].valid && (row_in[w].tag == tag);
      free[w]   = in_use[w] && !row_in[w].valid;
    end

    // lowest-numbered way wins
    hit_idx  = '0;
    free_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_idx = WAY_W'(w);
      if (free[w]) free_idx = WAY_W'(w);
    end

    // oldest way, ties to the lowest index
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row_in[w].rank > row_in[victim].rank)) victim = WAY_W'(w);
    end

    hit       = |match;
    have_free = !hit && (|free);
    evict     = !hit && !have_free;
    target    = hit ? hit_idx : (have_free ? free_idx : victim);
    limit     = row_in[target].rank;

    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w] = row_in[w];
      if (WAY_W'(w) == target) begin
        row_out[w].rank = '0;
        if (!hit) begin
          row_out[w].tag   = tag;
          row_out[w].valid = 1'b1;
        end
      end else if (in_use[w] && row_in[w].valid &&
                   (have_free || (row_in[w].rank < limit)) &&
                   (row_in[w].rank < RANK_W'(RANK_MAX))) begin
        row_out[w].rank = row_in[w].rank + RANK_W'(1);
      end
    end

    res.hit   = hit;
    res.evict = evict;
  end

endmodule

// File: sv/set_assoc_lru_cache_tag_model.sv
// an accepted word's set row is read synchronously into rd_row; in S_LOOKUP it is compared,
// replaced and written back, and the result is registered; S_LOOKUP holds while m_tready
// stalls, and s_tready is high only in S_IDLE, so a new word waits until the lookup finishes
// reset: counters, configuration and per-set valid flags clear; there is no clearing pass,
// and a set never written since reset reads as all lines invalid
module set_assoc_lru_cache_tag_model import salc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ADDR_W-1:0]   s_tdata,  // address
  input  logic [1:0]          s_tuser,  // operation
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [3*CNT_W-1:0]  m_tdata,  // hit_count, miss_count, eviction_count
  output logic [1:0]          m_tuser   // access_hit, access_evicted
);

  logic [3:0]        idx_width;
  logic [5:0]        blk_width;
  logic [3:0]        ways;

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              finish;

  logic [3:0]        sb;
  logic [6:0]        split;
  logic [SET_W:0]    idx_mask;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag_in;
  logic [WAY_W:0]    nw;

  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [1:0]        op_q;
  logic              op_ok;

  row_t              mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_valid;
  row_t              rd_row;
  logic              rd_ok;
  row_t              cur_row;
  row_t              new_row;
  upd_res_t          upd;

  logic [CNT_W-1:0]  hits_total;
  logic [CNT_W-1:0]  misses_total;
  logic [CNT_W-1:0]  evictions_total;
  logic [CNT_W:0]    hits_sum;
  logic [CNT_W:0]    misses_sum;
  logic [CNT_W:0]    evict_sum;
  logic [1:0]        hits_add;
  logic              acc_hit;
  logic              acc_evict;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_width <= '0;
      blk_width <= '0;
      ways      <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH: idx_width <= cfg_data[3:0];
        CFG_BLK_WIDTH: blk_width <= cfg_data;
        CFG_WAYS:      ways      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    sb       = (idx_width > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : idx_width;
    split    = 7'(sb) + 7'(blk_width);
    idx_mask = ((SET_W+1)'(1) << sb) - (SET_W+1)'(1);
    set_idx  = SET_W'(s_tdata >> blk_width) & idx_mask[SET_W-1:0];
    tag_in   = (split >= 7'd64) ? '0 : (s_tdata >> split);
    if (ways == 4'd0) begin
      nw = (WAY_W+1)'(1);
    end else if (ways > 4'(MAX_WAYS)) begin
      nw = (WAY_W+1)'(MAX_WAYS);
    end else begin
      nw = (WAY_W+1)'(ways);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_LOOKUP;
      S_LOOKUP: if (finish) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    finish   = 1'b0;
    unique case (state)
      S_IDLE:   s_tready = !rst;
      S_LOOKUP: finish = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_idx;
      tag_q <= tag_in;
      op_q  <= s_tuser;
    end
  end

  assign op_ok = (op_q == OP_LOAD) || (op_q == OP_STORE) || (op_q == OP_MODIFY);

  // tag memory, one row per set
  always_ff @(posedge clk) begin
    if (finish && op_ok) mem[set_q] <= new_row;
    if (accept) rd_row <= mem[set_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (finish && op_ok) row_valid[set_q] <= 1'b1;
      if (accept) rd_ok <= row_valid[set_idx];
    end
  end

  assign cur_row = rd_ok ? rd_row : '0;

  salc_update u_update (
    .row_in  (cur_row),
    .tag     (tag_q),
    .nw      (nw),
    .row_out (new_row),
    .res     (upd)
  );

  // a modify always hits on its second access
  always_comb begin
    hits_add   = 2'(upd.hit) + 2'(op_q == OP_MODIFY);
    hits_sum   = (CNT_W+1)'(hits_total) + (CNT_W+1)'(hits_add);
    misses_sum = (CNT_W+1)'(misses_total) + (CNT_W+1)'(!upd.hit);
    evict_sum  = (CNT_W+1)'(evictions_total) + (CNT_W+1)'(upd.evict);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
      acc_hit         <= 1'b0;
      acc_evict       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (finish) begin
        m_tvalid <= 1'b1;
        if (op_ok) begin
          hits_total      <= hits_sum[CNT_W] ? '1 : hits_sum[CNT_W-1:0];
          misses_total    <= misses_sum[CNT_W] ? '1 : misses_sum[CNT_W-1:0];
          evictions_total <= evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
          acc_hit         <= upd.hit;
          acc_evict       <= upd.evict;
        end else begin
          acc_hit   <= 1'b0;
          acc_evict <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {evictions_total, misses_total, hits_total};
  assign m_tuser = {acc_evict, acc_hit};

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOOKUP)
    else $error("accepted word did not start a lookup");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_LOOKUP))
    else $error("result appeared without a lookup");

  a_hit_or_evict: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOKUP |-> !(upd.hit && upd.evict))
    else $error("hit and eviction in the same access");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !finish |=> hits_total == $past(hits_total))
    else $error("hit counter moved without a result");

endmodule
